// File: hw/rtl/dct_pkg.sv
// Shared types, constants and command/status bundles for the disciplined counter timestamp.
`default_nettype none

package dct_pkg;

    // Field widths of the request and response.
    localparam int SYS_TIME_W = 63;
    localparam int CNT_IN_W   = 39;
    localparam int SEC_W      = 41;
    localparam int USEC_W     = 21;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Defaults for the top-level parameters.
    localparam int COUNTER_BITS_DEF = 39;
    localparam int WINDOW_TICKS_DEF = 1000000;

    // Time base: 100 ns ticks per second, and the 1601 to 1970 distance in ticks.
    localparam int                TICKS_W       = 24;
    localparam logic [TICKS_W-1:0] TICKS_PER_SEC = 24'd10000000;
    localparam logic [63:0]       EPOCH_DIFF    = 64'd116444736000000000;

    // Exact divide by ten for values below 2^32: multiply and keep bits above USEC_SHIFT.
    localparam logic [31:0] USEC_RECIP = 32'hCCCCCCCD;
    localparam int          USEC_SHIFT = 35;

    // Shared divider geometry.
    localparam int DIV_W     = 64;
    localparam int DIVISOR_W = 32;
    localparam int DIV_STEPS = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ   = 1'b0,
        CFG_ENABLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DIV_SCALE = 2'd0,
        DIV_WRAP  = 2'd1,
        DIV_SEC   = 2'd2
    } t_div_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE_GO,
        S_SCALE_WAIT,
        S_INIT,
        S_WRAP_GO,
        S_WRAP_WAIT,
        S_SUM,
        S_CHECK,
        S_FIX,
        S_REL,
        S_ABS,
        S_SEC_GO,
        S_SEC_WAIT,
        S_USEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_scaled;
        logic     init;
        logic     add_wrap;
        logic     sum;
        logic     check;
        logic     fix;
        logic     rel;
        logic     absval;
        logic     take_sec;
        logic     usec;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic enable;
        logic wrap;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/dct_div.sv
// Iterative restoring divider, STEPS quotient bits per cycle.
`default_nettype none

module dct_div #(
    parameter int W     = dct_pkg::DIV_W,
    parameter int DW    = dct_pkg::DIVISOR_W,
    parameter int STEPS = dct_pkg::DIV_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [W-1:0]       o_quotient,
    output logic [DW-1:0]      o_remainder
);

    localparam int ITER  = W / STEPS;
    localparam int CNT_W = $clog2(ITER + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [W-1:0]     n_quo;
    logic [DW-1:0]    n_rem;
    logic [DW:0]      trial;
    logic [DW:0]      diff;

    // The dividend shifts out of the top of r_quo while quotient bits shift in below.
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        diff  = '0;
        for (int k = 0; k < STEPS; k++) begin
            trial = {n_rem, n_quo[W-1]};
            diff  = trial - {1'b0, r_den};
            if (trial >= {1'b0, r_den}) begin
                n_rem = diff[DW-1:0];
                n_quo = {n_quo[W-2:0], 1'b1};
            end else begin
                n_rem = trial[DW-1:0];
                n_quo = {n_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: hw/rtl/dct_dp.sv
// Datapath: configuration, offset state, scaling, window test and seconds/microseconds split.
`default_nettype none

module dct_dp #(
    parameter int COUNTER_BITS = dct_pkg::COUNTER_BITS_DEF,
    parameter int WINDOW_TICKS = dct_pkg::WINDOW_TICKS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire dct_pkg::t_dp_cmd                  i_cmd,
    output dct_pkg::t_dp_status                    o_status,
    input  wire logic                              i_cfg_valid,
    input  wire logic [dct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [dct_pkg::SYS_TIME_W-1:0]    i_system_time,
    input  wire logic [dct_pkg::CNT_IN_W-1:0]      i_counter_value,
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output logic signed [dct_pkg::SEC_W-1:0]       o_seconds,
    output logic signed [dct_pkg::USEC_W-1:0]      o_microseconds
);

    import dct_pkg::*;

    localparam int          PW      = COUNTER_BITS + TICKS_W;
    localparam int          UPW     = TICKS_W + 32;
    localparam logic [63:0] WrapNum = 64'(TICKS_PER_SEC) << COUNTER_BITS;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]   r_freq;
    logic                    r_enable;

    // State kept across requests.
    logic [63:0]             r_offset;
    logic [63:0]             r_last;
    logic                    r_started;

    // Per-request working registers.
    logic [SYS_TIME_W-1:0]   r_t;
    logic [COUNTER_BITS-1:0] r_cnt;
    logic [63:0]             r_prod;
    logic [63:0]             r_scaled;
    logic                    r_wrap;
    logic [63:0]             r_sum;
    logic                    r_outside;
    logic [63:0]             r_diff;
    logic [63:0]             r_stamp;
    logic [63:0]             r_rel;
    logic                    r_neg;
    logic [63:0]             r_abs;
    logic [SEC_W-1:0]        r_sec_mag;
    logic [TICKS_W-1:0]      r_rem_sec;
    logic [UPW-1:0]          r_us_prod;
    logic                    r_rsp_valid;
    logic [SEC_W-1:0]        r_seconds;
    logic [USEC_W-1:0]       r_usec;

    logic [DIVISOR_W-1:0]    freq_eff;
    logic [PW-1:0]           prod_c;
    logic [DIV_W-1:0]        div_dividend;
    logic [DIVISOR_W-1:0]    div_divisor;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;
    logic [DIVISOR_W-1:0]    div_rem;
    logic signed [65:0]      sum_x;
    logic signed [65:0]      win_hi;
    logic signed [65:0]      win_lo;
    logic                    outside;
    logic [USEC_W-1:0]       usec_mag;

    // A zero frequency falls back to the nominal 10 MHz.
    assign freq_eff = (r_freq == '0) ? DIVISOR_W'(TICKS_PER_SEC) : r_freq;
    assign prod_c   = PW'(r_cnt) * PW'(TICKS_PER_SEC);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_SCALE: begin
                div_dividend = r_prod;
                div_divisor  = freq_eff;
            end
            DIV_WRAP: begin
                div_dividend = WrapNum;
                div_divisor  = freq_eff;
            end
            DIV_SEC: begin
                div_dividend = r_abs;
                div_divisor  = DIVISOR_W'(TICKS_PER_SEC);
            end
            default: begin
                div_dividend = r_prod;
                div_divisor  = freq_eff;
            end
        endcase
    end

    dct_div #(
        .W     (DIV_W),
        .DW    (DIVISOR_W),
        .STEPS (DIV_STEPS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // The window test runs at 66 bits so that neither bound nor the signed sum can overflow.
    assign sum_x   = {{2{r_sum[63]}}, r_sum};
    assign win_hi  = $signed(66'(r_t) + 66'(WINDOW_TICKS));
    assign win_lo  = $signed(66'(r_t) - 66'(WINDOW_TICKS));
    assign outside = (sum_x > win_hi) || (sum_x < win_lo);

    assign usec_mag = r_us_prod[USEC_SHIFT +: USEC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq   <= CFG_DATA_W'(TICKS_PER_SEC);
            r_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FREQ:   r_freq   <= i_cfg_data;
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default:    r_enable <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_last    <= '0;
            r_started <= 1'b0;
        end else if (i_cmd.init) begin
            if (!r_started) begin
                r_offset  <= 64'(r_t) - r_scaled;
                r_started <= 1'b1;
            end
            r_last <= r_scaled;
        end else if (i_cmd.add_wrap) begin
            r_offset <= r_offset + div_quo;
        end else if (i_cmd.fix && r_outside) begin
            r_offset <= r_offset + r_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t     <= i_system_time;
            r_cnt   <= i_counter_value[COUNTER_BITS-1:0];
            r_stamp <= 64'(i_system_time);
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(prod_c);
        end
        if (i_cmd.take_scaled) begin
            r_scaled <= div_quo;
        end
        if (i_cmd.init) begin
            // A backward step of the scaled counter means it wrapped.
            r_wrap <= (r_last > r_scaled);
        end
        if (i_cmd.sum) begin
            r_sum <= r_scaled + r_offset;
        end
        if (i_cmd.check) begin
            r_outside <= outside;
            r_diff    <= 64'(r_t) - r_sum;
        end
        if (i_cmd.fix) begin
            r_stamp <= r_outside ? 64'(r_t) : r_sum;
        end
        if (i_cmd.rel) begin
            r_rel <= r_stamp - EPOCH_DIFF;
        end
        if (i_cmd.absval) begin
            r_neg <= r_rel[63];
            r_abs <= r_rel[63] ? (64'd0 - r_rel) : r_rel;
        end
        if (i_cmd.take_sec) begin
            r_sec_mag <= div_quo[SEC_W-1:0];
            r_rem_sec <= div_rem[TICKS_W-1:0];
        end
        if (i_cmd.usec) begin
            r_us_prod <= UPW'(r_rem_sec) * UPW'(USEC_RECIP);
        end
        if (i_cmd.out_load) begin
            r_seconds <= r_neg ? (SEC_W'(0) - r_sec_mag) : r_sec_mag;
            r_usec    <= r_neg ? (USEC_W'(0) - usec_mag) : usec_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_status.enable   = r_enable;
    assign o_status.wrap     = r_wrap;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_rsp_valid || i_rsp_ready;

    assign o_rsp_valid    = r_rsp_valid;
    assign o_seconds      = $signed(r_seconds);
    assign o_microseconds = $signed(r_usec);

endmodule

`default_nettype wire

// File: hw/rtl/dct_ctrl.sv
// Controller state machine that sequences the datapath for one request at a time.
`default_nettype none

module dct_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire dct_pkg::t_dp_status  i_status,
    output dct_pkg::t_dp_cmd          o_cmd
);

    import dct_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    // With the counter disabled the stamp is the system time itself.
                    n_state = i_status.enable ? S_MUL : S_REL;
                end
            end
            S_MUL:        n_state = S_SCALE_GO;
            S_SCALE_GO:   n_state = S_SCALE_WAIT;
            S_SCALE_WAIT: if (i_status.div_done) n_state = S_INIT;
            S_INIT:       n_state = S_WRAP_GO;
            S_WRAP_GO:    n_state = i_status.wrap ? S_WRAP_WAIT : S_SUM;
            S_WRAP_WAIT:  if (i_status.div_done) n_state = S_SUM;
            S_SUM:        n_state = S_CHECK;
            S_CHECK:      n_state = S_FIX;
            S_FIX:        n_state = S_REL;
            S_REL:        n_state = S_ABS;
            S_ABS:        n_state = S_SEC_GO;
            S_SEC_GO:     n_state = S_SEC_WAIT;
            S_SEC_WAIT:   if (i_status.div_done) n_state = S_USEC;
            S_USEC:       n_state = S_OUT;
            S_OUT:        if (i_status.out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.div_sel = DIV_SCALE;
        unique case (r_state)
            S_IDLE:       o_cmd.load = i_req_valid;
            S_MUL:        o_cmd.mul = 1'b1;
            S_SCALE_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SCALE;
            end
            S_SCALE_WAIT: o_cmd.take_scaled = i_status.div_done;
            S_INIT:       o_cmd.init = 1'b1;
            S_WRAP_GO: begin
                o_cmd.div_start = i_status.wrap;
                o_cmd.div_sel   = DIV_WRAP;
            end
            S_WRAP_WAIT:  o_cmd.add_wrap = i_status.div_done;
            S_SUM:        o_cmd.sum = 1'b1;
            S_CHECK:      o_cmd.check = 1'b1;
            S_FIX:        o_cmd.fix = 1'b1;
            S_REL:        o_cmd.rel = 1'b1;
            S_ABS:        o_cmd.absval = 1'b1;
            S_SEC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SEC;
            end
            S_SEC_WAIT:   o_cmd.take_sec = i_status.div_done;
            S_USEC:       o_cmd.usec = 1'b1;
            S_OUT:        o_cmd.out_load = i_status.out_free;
            default:      o_cmd.load = 1'b0;
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/disciplined_counter_timestamp_top.sv
// Request time is set by the 64-bit divider, two quotient bits per cycle: one pass scales the
// counter, a second adds the wrap when one is seen and a third splits seconds, so one to three
// passes per request; with the counter disabled only the seconds pass runs.
// Throughput: one request in flight; the next is taken once the previous result is loaded
// into the output register, even while that result still waits to be taken.
// Reset (synchronous, active low): frequency 10 MHz, counter enabled, offset state cleared.
`default_nettype none

module disciplined_counter_timestamp_top #(
    parameter int COUNTER_BITS = dct_pkg::COUNTER_BITS_DEF,
    parameter int WINDOW_TICKS = dct_pkg::WINDOW_TICKS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_req_valid,
    output logic                                   o_req_ready,
    input  wire logic [dct_pkg::SYS_TIME_W-1:0]    i_system_time,
    input  wire logic [dct_pkg::CNT_IN_W-1:0]      i_counter_value,
    output logic                                   o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    output logic signed [dct_pkg::SEC_W-1:0]       o_seconds,
    output logic signed [dct_pkg::USEC_W-1:0]      o_microseconds
);

    import dct_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // User must send configuration writes only while idle (not enforced); port never stalls.
    assign o_cfg_ready = 1'b1;

    dct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dct_dp #(
        .COUNTER_BITS (COUNTER_BITS),
        .WINDOW_TICKS (WINDOW_TICKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_system_time   (i_system_time),
        .i_counter_value (i_counter_value),
        .o_rsp_valid     (o_rsp_valid),
        .i_rsp_ready     (i_rsp_ready),
        .o_seconds       (o_seconds),
        .o_microseconds  (o_microseconds)
    );

endmodule

`default_nettype wire

// File: hw/rtl/dct_chk.sv
// Port-level checker for the disciplined counter timestamp, bound to the top level.
`default_nettype none

module dct_chk (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              o_cfg_ready,
    input  wire logic [dct_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_req_valid,
    input  wire logic                              o_req_ready,
    input  wire logic [dct_pkg::SYS_TIME_W-1:0]    i_system_time,
    input  wire logic [dct_pkg::CNT_IN_W-1:0]      i_counter_value,
    input  wire logic                              o_rsp_valid,
    input  wire logic                              i_rsp_ready,
    input  wire logic signed [dct_pkg::SEC_W-1:0]  o_seconds,
    input  wire logic signed [dct_pkg::USEC_W-1:0] o_microseconds
);

    import dct_pkg::*;

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=>
            o_rsp_valid && $stable(o_seconds) && $stable(o_microseconds))
        else $error("response changed while stalled");

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request accepted while another is in progress");

    // The fraction stays within one second.
    a_usec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_microseconds <= 21'sd999999) && (o_microseconds >= -21'sd999999))
        else $error("microseconds out of range");

    // The fraction carries the sign of the whole seconds.
    a_usec_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_seconds != '0) |->
            (o_microseconds == '0) || (o_microseconds[USEC_W-1] == o_seconds[SEC_W-1]))
        else $error("microseconds sign differs from seconds");

endmodule

bind disciplined_counter_timestamp_top dct_chk u_dct_chk (.*);

`default_nettype wire
